[hw/rtl/gdbd_pkg.sv]
// Shared types, constants and calendar tables for the Gregorian day counter.
// No dependencies; imported by gdbd_div100 and gregorian_days_between_dates_unit.
package gdbd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   // Day ordinal from 1 January of year 0; the largest 14-bit year stays below 2**23
   localparam int ORD_W   = 23;

   // Divide by 100 through a reciprocal that never overestimates the quotient
   localparam int DIV_RECIP   = 5242;
   localparam int DIV_SHIFT   = 19;
   localparam int DIV_PROD_W  = YEAR_W + 13;
   localparam int QUOT_W      = 8;
   localparam int REM_W       = 7;
   localparam int DIVISOR     = 100;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [ORD_W-1:0]   DAYS_PER_YEAR = ORD_W'(365);
   localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } div100_res_type;

   // Days before the first of the month in a common year; zero for unusable months
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] days;
      unique case (m)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // Month length; zero for months outside January to December
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

[hw/rtl/gregorian_days_between_dates_unit.sv]
// Top level of the Gregorian day counter: sequencer, ordinal accumulator, output register.
// Depends on gdbd_pkg and gdbd_div100.
//
//   channel   ports                          direction   handshake
//   request   req_valid/req_ready, req_*     in          valid/ready
//   response  rsp_valid/rsp_ready, rsp_*     out         valid/ready
//   config    csr_write_en, csr_write_data   in          write strobe
//
// A transaction runs through YEAR_DIV, YEAR_WAIT, LEAP, MONTH and YTERM for each date,
// then DONE; the divide-by-100 unit is used twice per date, each time through its two registers.
// The next request is taken once the sequencer is back in idle, while a response may
// still wait in the output register; a stalled response holds the sequencer at its end.
// Synchronous reset clears the sequencer, the response valid and include_end_day.
module gregorian_days_between_dates_unit #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gdbd_pkg::DAY_W-1:0]   req_start_day,
   input  logic [gdbd_pkg::MONTH_W-1:0] req_start_month,
   input  logic [gdbd_pkg::YEAR_W-1:0]  req_start_year,
   input  logic [gdbd_pkg::DAY_W-1:0]   req_end_day,
   input  logic [gdbd_pkg::MONTH_W-1:0] req_end_month,
   input  logic [gdbd_pkg::YEAR_W-1:0]  req_end_year,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gdbd_pkg::COUNT_W-1:0] rsp_day_count,
   output logic                         rsp_bad_date,
   input  logic                         csr_write_en,
   input  logic                         csr_write_data
);
   import gdbd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_YEAR_DIV,
      S_YEAR_WAIT,
      S_LEAP,
      S_MONTH,
      S_YTERM,
      S_DONE
   } state_type;

   state_type state_ff;
   logic sel_ff;
   logic inc_ff;
   logic bad_ff, bad_in;
   logic leap_ff, leap_in;
   logic [ORD_W-1:0] acc_ff, a_ff;
   logic [DAY_W-1:0] sd_ff, ed_ff;
   logic [MONTH_W-1:0] sm_ff, em_ff;
   logic [YEAR_W-1:0] sy_ff, ey_ff;
   logic rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_bad_ff;

   logic [DAY_W-1:0] cur_d;
   logic [MONTH_W-1:0] cur_m;
   logic [YEAR_W-1:0] cur_y, prev_y;
   logic [YEAR_W-1:0] div_op;
   div100_res_type div_res;
   logic [11:0] year_term;
   logic [ORD_W-1:0] month_term;
   logic [ORD_W:0] diff;
   logic out_free;

   // Select the date under work
   always_comb begin
      cur_d  = sel_ff ? ed_ff : sd_ff;
      cur_m  = sel_ff ? em_ff : sm_ff;
      cur_y  = sel_ff ? ey_ff : sy_ff;
      prev_y = cur_y - YEAR_W'(1);
      div_op = (state_ff == S_LEAP) ? prev_y : cur_y;
   end

   gdbd_div100 u_div100 (
      .clock   (clock),
      .operand (div_op),
      .result  (div_res)
   );

   // Leap year and date check from the quotient of the year itself
   always_comb begin
      leap_in = ((cur_y[1:0] == 2'd0) && (div_res.rem != REM_W'(0))) ||
                ((div_res.rem == REM_W'(0)) && (div_res.quot[1:0] == 2'd0));
      bad_in  = bad_ff ||
                ({2'b00, cur_y} > 16'(MAX_YEAR)) ||
                (cur_d == DAY_W'(0)) ||
                (cur_d > month_len(cur_m, leap_in));
   end

   // Leap days of earlier years, from the quotient of the year before
   always_comb begin
      year_term  = 12'(prev_y >> 2) - 12'(div_res.quot) + 12'(div_res.quot >> 2) + 12'd1;
      month_term = ORD_W'(month_start(cur_m)) + ORD_W'(cur_d) +
                   ORD_W'((cur_m > FEBRUARY) && leap_ff);
   end

   // Form the response from the two ordinals
   always_comb begin
      diff = (acc_ff > a_ff) ? {1'b0, acc_ff - a_ff} : '0;
      diff = diff + (ORD_W + 1)'(inc_ff);
      if (bad_ff) begin
         rsp_count_in = '0;
      end else if (diff > (ORD_W + 1)'(COUNT_MAX)) begin
         rsp_count_in = COUNT_MAX;
      end else begin
         rsp_count_in = COUNT_W'(diff);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Hold the include-end-day flag
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= 1'b0;
      end else if (csr_write_en) begin
         inc_ff <= csr_write_data;
      end
   end

   // Sequencer, accumulator and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken response unless a new one is loaded in its place
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  sd_ff    <= req_start_day;
                  sm_ff    <= req_start_month;
                  sy_ff    <= req_start_year;
                  ed_ff    <= req_end_day;
                  em_ff    <= req_end_month;
                  ey_ff    <= req_end_year;
                  sel_ff   <= 1'b0;
                  bad_ff   <= 1'b0;
                  state_ff <= S_YEAR_DIV;
               end
            end
            S_YEAR_DIV: state_ff <= S_YEAR_WAIT;
            S_YEAR_WAIT: state_ff <= S_LEAP;
            S_LEAP: begin
               leap_ff  <= leap_in;
               bad_ff   <= bad_in;
               acc_ff   <= ORD_W'(cur_y) * DAYS_PER_YEAR;
               state_ff <= S_MONTH;
            end
            S_MONTH: begin
               acc_ff   <= acc_ff + month_term;
               state_ff <= S_YTERM;
            end
            S_YTERM: begin
               if (cur_y != YEAR_W'(0)) begin
                  acc_ff <= acc_ff + ORD_W'(year_term);
               end
               if (!sel_ff) begin
                  a_ff     <= (cur_y != YEAR_W'(0)) ? acc_ff + ORD_W'(year_term) : acc_ff;
                  sel_ff   <= 1'b1;
                  state_ff <= S_YEAR_DIV;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_count_ff <= rsp_count_in;
                  rsp_bad_ff   <= bad_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_day_count = rsp_count_ff;
   assign rsp_bad_date  = rsp_bad_ff;

   // Accepted transaction starts the year division
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_YEAR_DIV)
      else $error("sequencer did not start after acceptance");

   // Remainder from the shared divider is below the divisor when used
   a_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LEAP || state_ff == S_YTERM |-> div_res.rem < REM_W'(DIVISOR))
      else $error("divide-by-100 remainder out of range");

   // A bad date never carries a count
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_count_ff == '0)
      else $error("bad date response with nonzero count");

   // Both dates are done before the response is formed
   a_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> sel_ff)
      else $error("response formed before end date");

endmodule

[hw/rtl/gdbd_div100.sv]
// Shared two-stage divide-by-100 unit: reciprocal multiply, then one correction step.
// Depends on gdbd_pkg. The result is registered behind the estimate and operand registers.
module gdbd_div100 (
   input  logic                        clock,
   input  logic [gdbd_pkg::YEAR_W-1:0] operand,
   output gdbd_pkg::div100_res_type    result
);
   import gdbd_pkg::*;

   logic [QUOT_W-1:0] qest_ff, qest_in;
   logic [YEAR_W-1:0] op_ff;
   logic [DIV_PROD_W-1:0] prod;
   logic [YEAR_W-1:0] rest;
   div100_res_type res_ff, res_in;

   // Estimate the quotient: floor or one below
   always_comb begin
      prod    = DIV_PROD_W'(operand) * DIV_PROD_W'(DIV_RECIP);
      qest_in = QUOT_W'(prod >> DIV_SHIFT);
   end

   // Correct the estimate with one compare and subtract
   always_comb begin
      rest = op_ff - YEAR_W'(qest_ff) * YEAR_W'(DIVISOR);
      if (rest >= YEAR_W'(DIVISOR)) begin
         res_in.quot = qest_ff + QUOT_W'(1);
         res_in.rem  = REM_W'(rest - YEAR_W'(DIVISOR));
      end else begin
         res_in.quot = qest_ff;
         res_in.rem  = REM_W'(rest);
      end
   end

   always_ff @(posedge clock) begin
      qest_ff <= qest_in;
      op_ff   <= operand;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule
